// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros used by the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is asserted (active low)
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");

// clocked property that also holds during reset
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ----- rtl/eos_pkg.sv -----
// ----------------------------------------------------------------------------
// eos_pkg
// shared constants and types of the elevator order scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eos_pkg;

    // number of floors served, one bit per floor in every call vector
    localparam int FLOORS  = 4;
    localparam int FLOOR_W = (FLOORS > 1) ? $clog2(FLOORS) : 1;

    typedef enum logic [2:0] {
        OP_LATCH      = 3'd0,
        OP_FLOOR      = 3'd1,
        OP_TARGET     = 3'd2,
        OP_DIRECTION  = 3'd3,
        OP_CLEAR_HERE = 3'd4,
        OP_CLEAR_ALL  = 3'd5,
        OP_EMERGENCY  = 3'd6,
        OP_QUERY      = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

endpackage

`default_nettype wire

// ----- rtl/elevator_order_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// elevator_order_scheduler_top
// scan-style order book for one elevator car with one status result per op
// ----------------------------------------------------------------------------
// usage:
//   s_* channel carries one operation per transfer (opcode, button vectors,
//   floor sensors and a query floor); m_* channel returns one status word
//   per operation, in order, with the state as it stands after that op
//   path: each operation passes the input register, then the result
//   register, and m_valid rises once the result register is loaded
//   throughput: one operation per cycle while m_ready stays high; every op
//   is a single pass of small priority encoders over the floor vectors
//   between the two registers
//   stall: when m_ready is low the result register holds; the input
//   register still takes one more transfer, after which s_ready drops
//   until the result is taken
//   reset: aresetn low (synchronous) empties both registers and returns
//   all order vectors, floor, direction, target and emergency flag to zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module elevator_order_scheduler_top (
    input  wire                              aclk,
    input  wire                              aresetn,
    // operation input
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [2:0]                       s_req_type,
    input  wire  [eos_pkg::FLOORS-1:0]       s_up_buttons,
    input  wire  [eos_pkg::FLOORS-1:0]       s_down_buttons,
    input  wire  [eos_pkg::FLOORS-1:0]       s_inside_buttons,
    input  wire  [eos_pkg::FLOORS-1:0]       s_floor_sensors,
    input  wire  [eos_pkg::FLOOR_W-1:0]      s_query_floor,
    // status output
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [1:0]                       m_motion_dir,
    output logic [eos_pkg::FLOOR_W-1:0]      m_goal_floor,
    output logic [eos_pkg::FLOOR_W-1:0]      m_known_floor,
    output logic [eos_pkg::FLOORS-1:0]       m_up_calls,
    output logic [eos_pkg::FLOORS-1:0]       m_down_calls,
    output logic [eos_pkg::FLOORS-1:0]       m_cabin_calls,
    output logic                             m_any_pending,
    output logic                             m_at_goal,
    output logic                             m_at_any_floor,
    output logic                             m_query_hit,
    output logic                             m_emergency_flag
);

    localparam int F  = eos_pkg::FLOORS;
    localparam int FW = eos_pkg::FLOOR_W;

    // ------------------------------------------------------------------
    // handshake control
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic s_fire;      // input transfer
    logic out_free;    // result register can take a new result
    logic exec;        // operation in the input register runs this cycle

    assign out_free = !out_valid_reg || m_ready;
    assign exec     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_fire   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // input register (payload needs no reset)
    // ------------------------------------------------------------------
    eos_pkg::op_t   in_op_reg;
    logic [F-1:0]   in_up_reg;
    logic [F-1:0]   in_down_reg;
    logic [F-1:0]   in_inside_reg;
    logic [F-1:0]   in_sens_reg;
    logic [FW-1:0]  in_query_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (exec) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_op_reg     <= eos_pkg::op_t'(s_req_type);
            in_up_reg     <= s_up_buttons;
            in_down_reg   <= s_down_buttons;
            in_inside_reg <= s_inside_buttons;
            in_sens_reg   <= s_floor_sensors;
            in_query_reg  <= s_query_floor;
        end
    end

    // ------------------------------------------------------------------
    // order book state
    // ------------------------------------------------------------------
    logic [F-1:0]   up_reg, up_next;
    logic [F-1:0]   down_reg, down_next;
    logic [F-1:0]   cabin_reg, cabin_next;
    logic           pending_reg, pending_next;
    logic [FW-1:0]  floor_reg, floor_next;
    eos_pkg::dir_t  dir_reg, dir_next;
    logic [FW-1:0]  goal_reg, goal_next;
    logic           emerg_reg, emerg_next;
    logic           hit_next;

    // ------------------------------------------------------------------
    // scans over the current state
    // ------------------------------------------------------------------
    logic [F-1:0]   lat_up, lat_down, lat_cabin, lat_any;
    logic [F-1:0]   any_now, upc_now, dnc_now;
    logic           sens_found;
    logic [FW-1:0]  sens_idx;       // lowest active sensor
    logic           low_found;
    logic [FW-1:0]  low_idx;        // lowest floor with any order
    logic           upa_found;
    logic [FW-1:0]  upa_idx;        // up sweep: lowest up/cabin at or above floor
    logic           upb_found;
    logic [FW-1:0]  upb_idx;        // up sweep turn: highest down/cabin above 0
    logic           dna_found;
    logic [FW-1:0]  dna_idx;        // down sweep: highest down/cabin in 1..floor
    logic           dnb_found;
    logic [FW-1:0]  dnb_idx;        // down sweep turn: lowest up/cabin below top
    eos_pkg::dir_t  flip_dir;
    logic [FW-1:0]  flip_floor;

    // latch merges the new buttons into the stored orders
    assign lat_up    = up_reg | in_up_reg;
    assign lat_down  = down_reg | in_down_reg;
    assign lat_cabin = cabin_reg | in_inside_reg;
    assign lat_any   = lat_up | lat_down | lat_cabin;

    assign any_now = up_reg | down_reg | cabin_reg;
    assign upc_now = up_reg | cabin_reg;
    assign dnc_now = down_reg | cabin_reg;

    // priority encoders, lowest-wins scans walk downward, highest-wins upward
    always_comb begin
        sens_found = 1'b0;
        sens_idx   = '0;
        low_found  = 1'b0;
        low_idx    = '0;
        upa_found  = 1'b0;
        upa_idx    = '0;
        dnb_found  = 1'b0;
        dnb_idx    = '0;
        for (int i = F - 1; i >= 0; i--) begin
            if (in_sens_reg[i]) begin
                sens_found = 1'b1;
                sens_idx   = FW'(i);
            end
            if (any_now[i]) begin
                low_found = 1'b1;
                low_idx   = FW'(i);
            end
            if (upc_now[i] && (FW'(i) >= floor_reg)) begin
                upa_found = 1'b1;
                upa_idx   = FW'(i);
            end
            if (upc_now[i] && (i < F - 1)) begin
                dnb_found = 1'b1;
                dnb_idx   = FW'(i);
            end
        end
    end

    always_comb begin
        upb_found = 1'b0;
        upb_idx   = '0;
        dna_found = 1'b0;
        dna_idx   = '0;
        for (int i = 1; i < F; i++) begin
            if (dnc_now[i]) begin
                upb_found = 1'b1;
                upb_idx   = FW'(i);
            end
            if (dnc_now[i] && (FW'(i) <= floor_reg)) begin
                dna_found = 1'b1;
                dna_idx   = FW'(i);
            end
        end
    end

    // direction flip: up turns down one floor higher, else turns up one lower
    always_comb begin
        if (dir_reg == eos_pkg::DIR_UP) begin
            flip_dir   = eos_pkg::DIR_DOWN;
            flip_floor = (floor_reg != FW'(F - 1)) ? floor_reg + FW'(1) : floor_reg;
        end else begin
            flip_dir   = eos_pkg::DIR_UP;
            flip_floor = (floor_reg != '0) ? floor_reg - FW'(1) : floor_reg;
        end
    end

    // ------------------------------------------------------------------
    // operation decode
    // ------------------------------------------------------------------
    always_comb begin
        up_next      = up_reg;
        down_next    = down_reg;
        cabin_next   = cabin_reg;
        pending_next = pending_reg;
        floor_next   = floor_reg;
        dir_next     = dir_reg;
        goal_next    = goal_reg;
        emerg_next   = emerg_reg;
        hit_next     = 1'b0;

        unique case (in_op_reg)
            eos_pkg::OP_LATCH: begin
                up_next      = lat_up;
                down_next    = lat_down;
                cabin_next   = lat_cabin;
                pending_next = |lat_any;
            end
            eos_pkg::OP_FLOOR: begin
                if (sens_found) begin
                    floor_next = sens_idx;
                end
            end
            eos_pkg::OP_TARGET: begin
                if (dir_reg == eos_pkg::DIR_NONE || emerg_reg) begin
                    // idle or emergency: nearest order from the bottom
                    if (low_found) begin
                        goal_next = low_idx;
                    end
                end else if (dir_reg == eos_pkg::DIR_UP) begin
                    if (upa_found) begin
                        goal_next = upa_idx;
                    end else if (upb_found) begin
                        goal_next = upb_idx;
                    end else begin
                        dir_next = eos_pkg::DIR_NONE;
                    end
                end else if (dir_reg == eos_pkg::DIR_DOWN) begin
                    if (dna_found) begin
                        goal_next = dna_idx;
                    end else if (dnb_found) begin
                        goal_next = dnb_idx;
                    end else begin
                        dir_next = eos_pkg::DIR_NONE;
                    end
                end else begin
                    // unused direction code settles to idle
                    dir_next = eos_pkg::DIR_NONE;
                end
            end
            eos_pkg::OP_DIRECTION: begin
                if (goal_reg == floor_reg && (|in_sens_reg)) begin
                    dir_next = eos_pkg::DIR_NONE;
                end else if (goal_reg > floor_reg) begin
                    if (dir_reg == eos_pkg::DIR_DOWN) begin
                        dir_next   = flip_dir;
                        floor_next = flip_floor;
                    end else begin
                        dir_next = eos_pkg::DIR_UP;
                    end
                end else if (goal_reg < floor_reg) begin
                    if (dir_reg == eos_pkg::DIR_UP) begin
                        dir_next   = flip_dir;
                        floor_next = flip_floor;
                    end else begin
                        dir_next = eos_pkg::DIR_DOWN;
                    end
                end else if (emerg_reg) begin
                    // between floors at the goal during emergency
                    emerg_next = 1'b0;
                    dir_next   = flip_dir;
                    floor_next = flip_floor;
                end
            end
            eos_pkg::OP_CLEAR_HERE: begin
                up_next    = up_reg & ~(F'(1) << floor_reg);
                down_next  = down_reg & ~(F'(1) << floor_reg);
                cabin_next = cabin_reg & ~(F'(1) << floor_reg);
            end
            eos_pkg::OP_CLEAR_ALL: begin
                up_next      = '0;
                down_next    = '0;
                cabin_next   = '0;
                pending_next = 1'b0;
            end
            eos_pkg::OP_EMERGENCY: begin
                emerg_next = 1'b1;
            end
            eos_pkg::OP_QUERY: begin
                up_next      = lat_up;
                down_next    = lat_down;
                cabin_next   = lat_cabin;
                pending_next = |lat_any;
                hit_next     = lat_any[in_query_reg];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_reg      <= '0;
            down_reg    <= '0;
            cabin_reg   <= '0;
            pending_reg <= 1'b0;
            floor_reg   <= '0;
            dir_reg     <= eos_pkg::DIR_NONE;
            goal_reg    <= '0;
            emerg_reg   <= 1'b0;
        end else if (exec) begin
            up_reg      <= up_next;
            down_reg    <= down_next;
            cabin_reg   <= cabin_next;
            pending_reg <= pending_next;
            floor_reg   <= floor_next;
            dir_reg     <= dir_next;
            goal_reg    <= goal_next;
            emerg_reg   <= emerg_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (exec) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            m_motion_dir     <= dir_next;
            m_goal_floor     <= goal_next;
            m_known_floor    <= floor_next;
            m_up_calls       <= up_next;
            m_down_calls     <= down_next;
            m_cabin_calls    <= cabin_next;
            m_any_pending    <= pending_next;
            m_at_goal        <= in_sens_reg[goal_next];
            m_at_any_floor   <= |in_sens_reg;
            m_query_hit      <= hit_next;
            m_emergency_flag <= emerg_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/eos_checker.sv -----
// ----------------------------------------------------------------------------
// eos_checker
// port-level checks of the elevator order scheduler, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module eos_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          m_valid,
    input wire                          m_ready,
    input wire [eos_pkg::FLOOR_W-1:0]   m_goal_floor,
    input wire [eos_pkg::FLOORS-1:0]    m_up_calls,
    input wire                          m_any_pending,
    input wire                          m_at_goal,
    input wire                          m_at_any_floor,
    input wire                          m_query_hit
);

    // part of the payload a stalled result must keep
    logic [eos_pkg::FLOOR_W+eos_pkg::FLOORS-1:0] held;

    assign held = {m_goal_floor, m_up_calls};

    // no result survives a reset
    `ASSERT_CLK_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_valid)

    // a stalled result transfer keeps its payload
    `ASSERT_CLK(a_stall_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(held))

    // a query hit means some order was latched
    `ASSERT_CLK(a_hit_pending, aclk, aresetn, m_valid && m_query_hit |-> m_any_pending)

    // the goal sensor is one of the floor sensors
    `ASSERT_CLK(a_goal_sensor, aclk, aresetn, m_valid && m_at_goal |-> m_at_any_floor)

endmodule

bind elevator_order_scheduler_top eos_checker u_eos_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_goal_floor  (m_goal_floor),
    .m_up_calls    (m_up_calls),
    .m_any_pending (m_any_pending),
    .m_at_goal     (m_at_goal),
    .m_at_any_floor(m_at_any_floor),
    .m_query_hit   (m_query_hit)
);

`default_nettype wire

// ----- tb/sv/tb_elevator_order_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// tb_elevator_order_scheduler_top
// self-checking bench for the elevator order scheduler: drives operations
// over the s_ channel, predicts each status word with its own order-book
// model and compares every m_ transfer field by field, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_elevator_order_scheduler_top;

    localparam int FLOORS  = eos_pkg::FLOORS;
    localparam int FLOOR_W = eos_pkg::FLOOR_W;

    // stall length for the back-pressure test, in clock cycles
    localparam int HOLD_CYCLES  = 64;
    // settle time after the last status word (two-stage pipeline)
    localparam int SETTLE_CYCLES = 8;
    // random operations per idling phase
    localparam int PHASE_ITEMS  = 530;

    // one operation as it crosses the input channel
    typedef struct packed {
        eos_pkg::op_t       op;
        logic [FLOORS-1:0]  up_b;
        logic [FLOORS-1:0]  down_b;
        logic [FLOORS-1:0]  cabin_b;
        logic [FLOORS-1:0]  sens;
        logic [FLOOR_W-1:0] qf;
    } car_cmd_t;

    // one status word as it leaves the result channel
    typedef struct packed {
        logic [1:0]         dir;
        logic [FLOOR_W-1:0] goal;
        logic [FLOOR_W-1:0] known;
        logic [FLOORS-1:0]  up;
        logic [FLOORS-1:0]  down;
        logic [FLOORS-1:0]  cabin;
        logic               pending;
        logic               at_goal;
        logic               at_any;
        logic               hit;
        logic               emerg;
    } car_status_t;

    // ------------------------------------------------------------------------
    // order book model plus the queue of status words it has predicted
    // ------------------------------------------------------------------------
    class car_order_book;
        logic [FLOORS-1:0]  up_q    = '0;
        logic [FLOORS-1:0]  down_q  = '0;
        logic [FLOORS-1:0]  cabin_q = '0;
        logic               pend_q  = 1'b0;
        logic [FLOOR_W-1:0] known_q = '0;
        logic [FLOOR_W-1:0] goal_q  = '0;
        eos_pkg::dir_t      dir_q   = eos_pkg::DIR_NONE;
        logic               emerg_q = 1'b0;
        car_status_t        status_q[$];
        int unsigned        mismatches = 0;

        function int pending();
            return status_q.size();
        endfunction

        function void latch_calls(car_cmd_t cmd);
            up_q    |= cmd.up_b;
            down_q  |= cmd.down_b;
            cabin_q |= cmd.cabin_b;
            pend_q   = |(up_q | down_q | cabin_q);
        endfunction

        // reverse travel: going up turns down one floor higher, anything
        // else turns up one floor lower, both clamped to the shaft
        function void flip_car();
            if (dir_q == eos_pkg::DIR_UP) begin
                dir_q = eos_pkg::DIR_DOWN;
                if (known_q < FLOORS - 1)
                    known_q++;
            end else begin
                dir_q = eos_pkg::DIR_UP;
                if (known_q > 0)
                    known_q--;
            end
        endfunction

        // directional scan; the downward scans stop at floor 1
        function void pick_goal();
            logic [FLOORS-1:0] all_c;
            logic [FLOORS-1:0] upward;
            logic [FLOORS-1:0] downward;
            int f;
            all_c    = up_q | down_q | cabin_q;
            upward   = up_q | cabin_q;
            downward = down_q | cabin_q;
            if (dir_q == eos_pkg::DIR_NONE || emerg_q) begin
                for (f = 0; f < FLOORS; f++)
                    if (all_c[f]) begin
                        goal_q = f[FLOOR_W-1:0];
                        return;
                    end
                return;
            end
            if (dir_q == eos_pkg::DIR_UP) begin
                for (f = int'(known_q); f < FLOORS; f++)
                    if (upward[f]) begin
                        goal_q = f[FLOOR_W-1:0];
                        return;
                    end
                for (f = FLOORS - 1; f > 0; f--)
                    if (downward[f]) begin
                        goal_q = f[FLOOR_W-1:0];
                        return;
                    end
            end else if (dir_q == eos_pkg::DIR_DOWN) begin
                for (f = int'(known_q); f > 0; f--)
                    if (downward[f]) begin
                        goal_q = f[FLOOR_W-1:0];
                        return;
                    end
                for (f = 0; f < FLOORS - 1; f++)
                    if (upward[f]) begin
                        goal_q = f[FLOOR_W-1:0];
                        return;
                    end
            end
            dir_q = eos_pkg::DIR_NONE;
        endfunction

        function void steer(logic some_floor);
            if (goal_q == known_q && some_floor) begin
                dir_q = eos_pkg::DIR_NONE;
            end else if (goal_q > known_q) begin
                if (dir_q == eos_pkg::DIR_DOWN) flip_car();
                else dir_q = eos_pkg::DIR_UP;
            end else if (goal_q < known_q) begin
                if (dir_q == eos_pkg::DIR_UP) flip_car();
                else dir_q = eos_pkg::DIR_DOWN;
            end else if (emerg_q) begin
                emerg_q = 1'b0;
                flip_car();
            end
        endfunction

        // apply one accepted operation and queue the status it must produce
        function void note_input(car_cmd_t cmd);
            car_status_t       st;
            logic [FLOORS-1:0] all_c;
            logic              hit;
            int                f;
            hit = 1'b0;
            case (cmd.op)
                eos_pkg::OP_LATCH: latch_calls(cmd);
                eos_pkg::OP_FLOOR: begin
                    for (f = 0; f < FLOORS; f++)
                        if (cmd.sens[f]) begin
                            known_q = f[FLOOR_W-1:0];
                            break;
                        end
                end
                eos_pkg::OP_TARGET:    pick_goal();
                eos_pkg::OP_DIRECTION: steer(|cmd.sens);
                eos_pkg::OP_CLEAR_HERE: begin
                    up_q[known_q]    = 1'b0;
                    down_q[known_q]  = 1'b0;
                    cabin_q[known_q] = 1'b0;
                end
                eos_pkg::OP_CLEAR_ALL: begin
                    up_q    = '0;
                    down_q  = '0;
                    cabin_q = '0;
                    pend_q  = 1'b0;
                end
                eos_pkg::OP_EMERGENCY: emerg_q = 1'b1;
                default: begin
                    latch_calls(cmd);
                    all_c = up_q | down_q | cabin_q;
                    hit   = all_c[cmd.qf];
                end
            endcase
            st.dir     = dir_q;
            st.goal    = goal_q;
            st.known   = known_q;
            st.up      = up_q;
            st.down    = down_q;
            st.cabin   = cabin_q;
            st.pending = pend_q;
            st.at_goal = cmd.sens[goal_q];
            st.at_any  = |cmd.sens;
            st.hit     = hit;
            st.emerg   = emerg_q;
            status_q.push_back(st);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(car_status_t got);
            car_status_t want;
            if (status_q.size() == 0) begin
                $error("status transfer with no operation outstanding");
                mismatches++;
                return;
            end
            want = status_q.pop_front();
            check_field("motion_dir", want.dir, got.dir);
            check_field("goal_floor", want.goal, got.goal);
            check_field("known_floor", want.known, got.known);
            check_field("up_calls", want.up, got.up);
            check_field("down_calls", want.down, got.down);
            check_field("cabin_calls", want.cabin, got.cabin);
            check_field("any_pending", want.pending, got.pending);
            check_field("at_goal", want.at_goal, got.at_goal);
            check_field("at_any_floor", want.at_any, got.at_any);
            check_field("query_hit", want.hit, got.hit);
            check_field("emergency_flag", want.emerg, got.emerg);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and dut ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic               aclk             = 1'b0;
    logic               aresetn          = 1'b0;
    logic               s_valid          = 1'b0;
    logic               s_ready;
    logic [2:0]         s_req_type       = '0;
    logic [FLOORS-1:0]  s_up_buttons     = '0;
    logic [FLOORS-1:0]  s_down_buttons   = '0;
    logic [FLOORS-1:0]  s_inside_buttons = '0;
    logic [FLOORS-1:0]  s_floor_sensors  = '0;
    logic [FLOOR_W-1:0] s_query_floor    = '0;
    logic               m_valid;
    logic               m_ready          = 1'b0;
    logic [1:0]         m_motion_dir;
    logic [FLOOR_W-1:0] m_goal_floor;
    logic [FLOOR_W-1:0] m_known_floor;
    logic [FLOORS-1:0]  m_up_calls;
    logic [FLOORS-1:0]  m_down_calls;
    logic [FLOORS-1:0]  m_cabin_calls;
    logic               m_any_pending;
    logic               m_at_goal;
    logic               m_at_any_floor;
    logic               m_query_hit;
    logic               m_emergency_flag;

    // idling knobs: percent of cycles the sender idles / receiver stalls
    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    // long receiver hold-off, raised by its own counting process
    logic        rx_hold      = 1'b0;
    event        hold_off_go;
    int unsigned items_sent   = 0;

    car_order_book book;

    elevator_order_scheduler_top uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_up_buttons     (s_up_buttons),
        .s_down_buttons   (s_down_buttons),
        .s_inside_buttons (s_inside_buttons),
        .s_floor_sensors  (s_floor_sensors),
        .s_query_floor    (s_query_floor),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_motion_dir     (m_motion_dir),
        .m_goal_floor     (m_goal_floor),
        .m_known_floor    (m_known_floor),
        .m_up_calls       (m_up_calls),
        .m_down_calls     (m_down_calls),
        .m_cabin_calls    (m_cabin_calls),
        .m_any_pending    (m_any_pending),
        .m_at_goal        (m_at_goal),
        .m_at_any_floor   (m_at_any_floor),
        .m_query_hit      (m_query_hit),
        .m_emergency_flag (m_emergency_flag)
    );

    // 8 ns clock period
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // receiver: checks each status transfer, then picks the next m_ready;
    // all reads here see the values from just before the edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            book.check_result(car_status_t'{m_motion_dir, m_goal_floor, m_known_floor,
                                            m_up_calls, m_down_calls, m_cabin_calls,
                                            m_any_pending, m_at_goal, m_at_any_floor,
                                            m_query_hit, m_emergency_flag});
        if (rx_hold)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // hold-off: keeps the receiver stalled until its counting loop runs out
    always begin
        @(hold_off_go);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [FLOORS-1:0] rand_bits();
        logic [31:0] r;
        r = $urandom;
        return r[FLOORS-1:0];
    endfunction

    function automatic logic [FLOOR_W-1:0] rand_floor();
        logic [31:0] r;
        r = $urandom;
        return r[FLOOR_W-1:0];
    endfunction

    function automatic eos_pkg::op_t rand_op();
        logic [31:0] r;
        r = $urandom;
        return eos_pkg::op_t'(r[2:0]);
    endfunction

    // button vectors: mostly a few calls, sometimes dense
    function automatic logic [FLOORS-1:0] some_calls();
        if ($urandom_range(3) == 0)
            return rand_bits();
        return rand_bits() & rand_bits();
    endfunction

    function automatic logic [FLOORS-1:0] one_hot(logic [FLOOR_W-1:0] fl);
        logic [FLOORS-1:0] v;
        v = '0;
        v[fl] = 1'b1;
        return v;
    endfunction

    // sensor pattern: car sitting at a floor, between floors, or noise
    function automatic logic [FLOORS-1:0] sensor_pick(logic [FLOOR_W-1:0] fl);
        int unsigned r;
        r = $urandom_range(9);
        if (r < 6) return one_hot(fl);
        if (r < 8) return '0;
        return rand_bits();
    endfunction

    // offer one operation and wait for its transfer; random idle gaps first
    task automatic issue_op(input eos_pkg::op_t op,
                            input logic [FLOORS-1:0] up_b, down_b, cabin_b,
                            input logic [FLOORS-1:0] sens, input logic [FLOOR_W-1:0] qf);
        car_cmd_t cmd;
        cmd = '{op, up_b, down_b, cabin_b, sens, qf};
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_req_type       <= op;
        s_up_buttons     <= up_b;
        s_down_buttons   <= down_b;
        s_inside_buttons <= cabin_b;
        s_floor_sensors  <= sens;
        s_query_floor    <= qf;
        do @(posedge aclk); while (!s_ready);
        book.note_input(cmd);
        items_sent++;
    endtask

    // sender pause: nothing offered until every status word is back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (book.pending() != 0);
    endtask

    // a well-formed service round: latch, locate, target, steer, then
    // maybe serve the floor, query, raise an emergency or wipe the book
    task automatic run_trip();
        logic [FLOOR_W-1:0] spot;
        int unsigned        r;
        spot = rand_floor();
        issue_op(eos_pkg::OP_LATCH, some_calls(), some_calls(), some_calls(), rand_bits(),
                 rand_floor());
        issue_op(eos_pkg::OP_FLOOR, rand_bits(), rand_bits(), rand_bits(),
                 ($urandom_range(2) == 0) ? sensor_pick(book.goal_q) : sensor_pick(spot),
                 rand_floor());
        issue_op(eos_pkg::OP_TARGET, rand_bits(), rand_bits(), rand_bits(), rand_bits(),
                 rand_floor());
        issue_op(eos_pkg::OP_DIRECTION, rand_bits(), rand_bits(), rand_bits(),
                 sensor_pick(book.goal_q), rand_floor());
        if ($urandom_range(1) == 0)
            issue_op(eos_pkg::OP_CLEAR_HERE, rand_bits(), rand_bits(), rand_bits(),
                     rand_bits(), rand_floor());
        r = $urandom_range(99);
        if (r < 25)
            issue_op(eos_pkg::OP_QUERY, some_calls(), some_calls(), some_calls(),
                     rand_bits(), rand_floor());
        else if (r < 30)
            issue_op(eos_pkg::OP_EMERGENCY, rand_bits(), rand_bits(), rand_bits(),
                     rand_bits(), rand_floor());
        else if (r < 35)
            issue_op(eos_pkg::OP_CLEAR_ALL, rand_bits(), rand_bits(), rand_bits(),
                     rand_bits(), rand_floor());
    endtask

    // mostly service rounds, the rest fully random operations
    task automatic run_random(input int unsigned count);
        int unsigned stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 80)
                run_trip();
            else
                issue_op(rand_op(), rand_bits(), rand_bits(), rand_bits(),
                         rand_bits(), rand_floor());
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        book = new;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed walk through every operation and the corner behaviors
        issue_op(eos_pkg::OP_QUERY, '0, '0, '0, '0, 2'd3);      // query on empty book
        issue_op(eos_pkg::OP_TARGET, '0, '0, '0, '0, '0);       // no orders, goal held
        issue_op(eos_pkg::OP_DIRECTION, '0, '0, '0, '0, '0);    // at goal, no sensor
        issue_op(eos_pkg::OP_LATCH, '1, '1, '1, '1, '1);        // every button at once
        issue_op(eos_pkg::OP_CLEAR_ALL, '0, '0, '0, '0, '0);
        issue_op(eos_pkg::OP_LATCH, 4'b1000, '0, '0, '0, '0);
        issue_op(eos_pkg::OP_FLOOR, '0, '0, '0, 4'b0000, '0);   // no sensor, floor kept
        issue_op(eos_pkg::OP_FLOOR, '0, '0, '0, 4'b0110, '0);   // lowest sensor wins
        issue_op(eos_pkg::OP_TARGET, '0, '0, '0, '0, '0);       // idle: lowest order
        issue_op(eos_pkg::OP_DIRECTION, '0, '0, '0, '0, '0);    // goal above: go up
        issue_op(eos_pkg::OP_LATCH, '0, 4'b0100, 4'b0001, '0, '0);
        issue_op(eos_pkg::OP_TARGET, '0, '0, '0, '0, '0);       // upward scan
        issue_op(eos_pkg::OP_FLOOR, '0, '0, '0, 4'b1000, '0);
        issue_op(eos_pkg::OP_DIRECTION, '0, '0, '0, 4'b1000, '0); // arrived: stop
        issue_op(eos_pkg::OP_CLEAR_HERE, '0, '0, '0, '0, '0);
        issue_op(eos_pkg::OP_QUERY, '0, '0, '0, '0, 2'd2);      // hit on a down call
        issue_op(eos_pkg::OP_TARGET, '0, '0, '0, '0, '0);
        issue_op(eos_pkg::OP_DIRECTION, '0, '0, '0, '0, '0);    // goal below: go down
        issue_op(eos_pkg::OP_TARGET, '0, '0, '0, '0, '0);       // downward scan
        issue_op(eos_pkg::OP_EMERGENCY, '0, '0, '0, '0, '0);
        issue_op(eos_pkg::OP_TARGET, '0, '0, '0, '0, '0);       // emergency: lowest order
        issue_op(eos_pkg::OP_DIRECTION, '0, '0, '0, '0, '0);
        issue_op(eos_pkg::OP_FLOOR, '0, '0, '0, 4'b0001, '0);
        issue_op(eos_pkg::OP_DIRECTION, '0, '0, '0, '0, '0);    // emergency flip at floor 0
        issue_op(eos_pkg::OP_FLOOR, '0, '0, '0, 4'b1000, '0);
        issue_op(eos_pkg::OP_DIRECTION, '0, '0, '0, '0, '0);    // flip clamps at top floor
        drain_results();

        // sender idles now and then, receiver mostly stalls
        tx_idle_pct = 21;
        rx_stall_pct <= 84;
        run_random(PHASE_ITEMS);
        drain_results();

        // sender mostly idles, receiver stalls now and then
        tx_idle_pct = 84;
        rx_stall_pct <= 21;
        run_random(PHASE_ITEMS);
        drain_results();

        // full rate; opens with a long receiver hold-off so the pipe
        // fills and s_ready drops while the sender keeps offering
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        -> hold_off_go;
        run_random(PHASE_ITEMS);

        s_valid <= 1'b0;
        do @(posedge aclk); while (book.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (book.mismatches == 0 && book.pending() == 0)
            $display("elevator_order_scheduler_top verification clean");
        else
            $display("elevator_order_scheduler_top verification failed");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #2000000;
        $display("elevator_order_scheduler_top verification failed");
        $finish;
    end

endmodule
